[design/sorted_multiset_table_assert.svh]
// ----------------------------------------------------------------------------
// Sorted multiset table assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_TABLE_ASSERT_SVH
`define SORTED_MULTISET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/smt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted multiset table package
// Field widths, operation and status codes, and the types shared by the row
// of cells and the controller.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  // Scan token handed from one cell to the next.
  typedef struct packed {
    logic valid;
    logic fail_seen;
  } smt_tok_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } smt_cmd_t;

endpackage

[design/smt_cell.sv]
// ----------------------------------------------------------------------------
// Sorted multiset table cell
// Holds one entry, records its place in the scan as the token passes, and
// shifts data with its neighbors when the update command arrives.
// ----------------------------------------------------------------------------
module smt_cell import smt_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      order_desc_i,
  input  logic signed [VALUE_W-1:0] op_value_i,
  input  logic [CW-1:0]             held_count_i,
  input  smt_tok_t                  tok_i,
  input  logic [CW-1:0]             rank_i,
  input  smt_cmd_t                  cmd_i,
  input  logic [CW-1:0]             total_i,
  input  logic signed [VALUE_W-1:0] left_data_i,
  input  logic signed [VALUE_W-1:0] right_data_i,
  output smt_tok_t                  tok_o,
  output logic [CW-1:0]             rank_o,
  output logic signed [VALUE_W-1:0] data_o
);

  logic signed [VALUE_W-1:0] data_q, data_d;
  logic                      valid_q;
  logic                      before_q;
  logic                      incl_q;
  logic [CW-1:0]             rank_q;
  logic                      occ;
  logic                      hit;
  logic                      in_ord;
  logic                      fail;

  assign occ    = held_count_i > CW'(IDX);
  assign hit    = occ && (data_q == op_value_i);
  assign in_ord = order_desc_i ? (data_q >= op_value_i) : (data_q <= op_value_i);
  // An empty cell always stops the insert search, so the end of the table
  // becomes the insert point when no held entry does.
  assign fail   = !occ || !in_ord;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      before_q <= 1'b0;
      incl_q   <= 1'b0;
      rank_q   <= '0;
    end else begin
      valid_q <= tok_i.valid;
      if (tok_i.valid) begin
        before_q <= tok_i.fail_seen;
        incl_q   <= tok_i.fail_seen | fail;
        rank_q   <= rank_i + CW'(hit);
      end
    end
  end

  // The last equal copy is the one whose running count reaches the total;
  // it and every cell after it take the right neighbor's entry.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (before_q) begin
        data_d = left_data_i;
      end else if (incl_q) begin
        data_d = op_value_i;
      end
    end
    if (cmd_i.rem && (rank_q == total_i)) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign tok_o  = '{valid: valid_q, fail_seen: incl_q};
  assign rank_o = rank_q;
  assign data_o = data_q;

endmodule

[design/smt_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted multiset table controller
// Takes one operation, launches the scan token into the cell row, and issues
// the update and the result once the token leaves the last cell.
// ----------------------------------------------------------------------------
`include "sorted_multiset_table_assert.svh"

module smt_ctrl import smt_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW       = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [MODE_W-1:0]           in_mode_i,
  input  logic signed [VALUE_W-1:0]   in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [STATUS_W-1:0]         out_status_o,
  output logic [OUT_CNT_W-1:0]        out_occurrences_o,
  output logic [OUT_CNT_W-1:0]        out_element_count_o,
  output logic                        out_is_empty_o,
  output logic                        order_desc_o,
  output logic signed [VALUE_W-1:0]   op_value_o,
  output logic [CW-1:0]               held_count_o,
  output smt_tok_t                    launch_o,
  input  smt_tok_t                    last_tok_i,
  input  logic [CW-1:0]               total_i,
  output smt_cmd_t                    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                state_q, state_d;
  logic                      order_desc_q;
  logic [MODE_W-1:0]         op_mode_q;
  logic signed [VALUE_W-1:0] op_value_q;
  logic [CW-1:0]             held_count_q, held_count_d;
  logic [CW-1:0]             total_q;
  logic                      launch_q;
  logic                      out_valid_q;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;
  logic [OUT_CNT_W-1:0]      out_occ_q;
  logic [OUT_CNT_W-1:0]      out_cnt_q;
  logic                      out_empty_q;
  logic                      accept;
  logic                      full;
  logic                      ins_do;
  logic                      rem_do;
  logic                      fire;
  logic [CW-1:0]             occ_next;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = held_count_q == CW'(CAPACITY);
  assign ins_do = (op_mode_q == MODE_INSERT) && !full;
  assign rem_do = (op_mode_q == MODE_REMOVE) && (total_q != '0);
  // The update waits until the output register can take the result.
  assign fire   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_tok_i.valid) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    held_count_d = held_count_q;
    occ_next     = total_q;
    if (ins_do) begin
      held_count_d = held_count_q + CW'(1);
      occ_next     = total_q + CW'(1);
    end else if (rem_do) begin
      held_count_d = held_count_q - CW'(1);
      occ_next     = total_q - CW'(1);
    end
  end

  always_comb begin
    if (op_mode_q == MODE_INSERT) begin
      out_status_d = full ? STATUS_FULL : STATUS_DONE;
    end else begin
      out_status_d = (total_q == '0) ? STATUS_ABSENT : STATUS_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      order_desc_q <= 1'b0;
      held_count_q <= '0;
      launch_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
      if (cfg_we_i) begin
        order_desc_q <= cfg_wdata_i;
      end
      if (fire) begin
        held_count_q <= held_count_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_mode_q  <= in_mode_i;
      op_value_q <= in_value_i;
    end
    if (last_tok_i.valid) begin
      total_q <= total_i;
    end
    if (fire) begin
      out_status_q <= out_status_d;
      out_occ_q    <= OUT_CNT_W'(occ_next);
      out_cnt_q    <= OUT_CNT_W'(held_count_d);
      out_empty_q  <= held_count_d == '0;
    end
  end

  assign in_stall_o          = state_q != ST_IDLE;
  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_occurrences_o   = out_occ_q;
  assign out_element_count_o = out_cnt_q;
  assign out_is_empty_o      = out_empty_q;
  assign order_desc_o        = order_desc_q;
  assign op_value_o          = op_value_q;
  assign held_count_o        = held_count_q;
  assign launch_o            = '{valid: launch_q, fail_seen: 1'b0};
  assign cmd_o               = '{ins: fire && ins_do, rem: fire && rem_do};

  `SMT_ASSERT_NOW(a_count_bound, 1'b1, held_count_q <= CW'(CAPACITY), "held count above capacity")
  `SMT_ASSERT_NOW(a_launch_in_scan, launch_q, state_q == ST_SCAN, "token launched outside a scan")
  `SMT_ASSERT_NEXT(a_token_to_apply, last_tok_i.valid, state_q == ST_APPLY, "scan end missed")
  `SMT_ASSERT_NEXT(a_insert_grows, cmd_o.ins, held_count_q == $past(held_count_q) + CW'(1), "insert count")
  `SMT_ASSERT_NOW(a_cmd_exclusive, cmd_o.ins || cmd_o.rem, fire && !(cmd_o.ins && cmd_o.rem), "bad update")

endmodule

[design/sorted_multiset_table.sv]
// ----------------------------------------------------------------------------
// Sorted multiset table
// Up to CAPACITY signed values held in order in a row of cells, with insert,
// remove-one-copy and count lookup operations.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake                Payload
//   in       in   in_valid_i / in_stall_o  in_mode_i, in_value_i
//   out      out  out_valid_o / out_stall_i out_status_o, out_occurrences_o,
//                                          out_element_count_o, out_is_empty_o
//   cfg      in   cfg_we_i                 cfg_wdata_i (descending order)
//
// Each operation holds the input stalled from its transfer until its update is
// applied, since the scan token walks the whole cell row one cell per cycle.
// The result is registered, so a stalled output holds only the update step.
// Reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_multiset_table import smt_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [MODE_W-1:0]           in_mode_i,
  input  logic signed [VALUE_W-1:0]   in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [STATUS_W-1:0]         out_status_o,
  output logic [OUT_CNT_W-1:0]        out_occurrences_o,
  output logic [OUT_CNT_W-1:0]        out_element_count_o,
  output logic                        out_is_empty_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                      order_desc;
  logic signed [VALUE_W-1:0] op_value;
  logic [CW-1:0]             held_count;
  smt_cmd_t                  cmd;
  smt_tok_t                  tok  [CAPACITY+1];
  logic [CW-1:0]             rank [CAPACITY+1];
  logic signed [VALUE_W-1:0] data [CAPACITY];

  assign rank[0] = '0;

  smt_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_mode_i           (in_mode_i),
    .in_value_i          (in_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_occurrences_o   (out_occurrences_o),
    .out_element_count_o (out_element_count_o),
    .out_is_empty_o      (out_is_empty_o),
    .order_desc_o        (order_desc),
    .op_value_o          (op_value),
    .held_count_o        (held_count),
    .launch_o            (tok[0]),
    .last_tok_i          (tok[CAPACITY]),
    .total_i             (rank[CAPACITY]),
    .cmd_o               (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_data;
    logic signed [VALUE_W-1:0] right_data;

    // The first cell never shifts from the left, and the last one has no right
    // neighbor and takes back its own entry in place of one.
    if (i == 0) begin : g_first
      assign left_data = op_value;
    end else begin : g_mid_left
      assign left_data = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = data[i];
    end else begin : g_mid_right
      assign right_data = data[i+1];
    end

    smt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .order_desc_i (order_desc),
      .op_value_i   (op_value),
      .held_count_i (held_count),
      .tok_i        (tok[i]),
      .rank_i       (rank[i]),
      .cmd_i        (cmd),
      .total_i      (rank[CAPACITY]),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .tok_o        (tok[i+1]),
      .rank_o       (rank[i+1]),
      .data_o       (data[i])
    );
  end

endmodule

[test/tb_sorted_multiset_table.sv]
// ----------------------------------------------------------------------------
// Sorted multiset table testbench
// Sends insert, remove and lookup transfers through the valid/stall channels
// and checks every reply against a software copy of the table, or against a
// fixed expected reply for typed directed rows. The sort order is flipped between
// phases while data is still held, and in most phases both sides idle and hold off at random.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_table import smt_pkg::*; ();

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned OP_CYCLES   = CAPACITY + 3;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 265;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned HOLD_AT     = 450;
  localparam int unsigned MAX_REPORTS = 10;

  // The spare operation code behaves as a lookup.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_CNT_W-1:0] occurrences;
    logic [OUT_CNT_W-1:0] element_count;
    logic                 is_empty;
  } reply_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    reply_t                    reply;
  } stim_row_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic                        cfg_wdata_i = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [MODE_W-1:0]           in_mode_i   = MODE_INSERT;
  logic signed [VALUE_W-1:0]   in_value_i  = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [STATUS_W-1:0]         out_status_o;
  logic [OUT_CNT_W-1:0]        out_occurrences_o;
  logic [OUT_CNT_W-1:0]        out_element_count_o;
  logic                        out_is_empty_o;

  // Software copy of the table.
  logic signed [VALUE_W-1:0] shadow_store [CAPACITY];
  int unsigned               shadow_held = 0;
  logic                      shadow_desc = 1'b0;

  reply_t      pending_replies [$];
  stim_row_t   directed_rows [$];
  int unsigned items_sent   = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned full_hits    = 0;
  int unsigned absent_hits  = 0;
  bit          idle_en      = 1'b1;
  bit          long_hold_done = 1'b0;
  int unsigned stall_left   = 0;

  sorted_multiset_table #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_value_i         (in_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_occurrences_o  (out_occurrences_o),
    .out_element_count_o(out_element_count_o),
    .out_is_empty_o     (out_is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned copies_of(logic signed [VALUE_W-1:0] v);
    int unsigned k;
    int unsigned i;
    k = 0;
    for (i = 0; i < shadow_held; i++)
      if (shadow_store[i] == v) k++;
    return k;
  endfunction

  // Applies one operation to the software table and returns its reply.
  function automatic reply_t multiset_update(logic [MODE_W-1:0] mode,
                                             logic signed [VALUE_W-1:0] v);
    reply_t      r;
    int unsigned pos;
    int unsigned k;
    int unsigned i;
    r.status = STATUS_DONE;
    if (mode == MODE_INSERT) begin
      if (shadow_held >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        // A new value goes after the leading run of elements already in order with it.
        pos = 0;
        while (pos < shadow_held &&
               (shadow_desc ? shadow_store[pos] >= v : shadow_store[pos] <= v))
          pos++;
        for (i = shadow_held; i > pos; i--) shadow_store[i] = shadow_store[i - 1];
        shadow_store[pos] = v;
        shadow_held++;
      end
    end else if (mode == MODE_REMOVE) begin
      k = shadow_held;
      for (i = 0; i < shadow_held; i++)
        if (shadow_store[i] == v) k = i;
      if (k < shadow_held) begin
        for (i = k; i + 1 < shadow_held; i++) shadow_store[i] = shadow_store[i + 1];
        shadow_held--;
      end else begin
        r.status = STATUS_ABSENT;
      end
    end else if (copies_of(v) == 0) begin
      r.status = STATUS_ABSENT;
    end
    r.occurrences   = OUT_CNT_W'(copies_of(v));
    r.element_count = OUT_CNT_W'(shadow_held);
    r.is_empty      = (shadow_held == 0);
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    // Small values collide often, which exercises duplicate handling.
    if (sel < 5) return $signed(VALUE_W'($urandom_range(0, 8))) - 32'sd4;
    return $signed($urandom);
  endfunction

  task automatic add_row(input logic [MODE_W-1:0] mode,
                         input logic signed [VALUE_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.mode  = mode;
    row.value = v;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [MODE_W-1:0] mode,
                           input logic signed [VALUE_W-1:0] v,
                           input logic [STATUS_W-1:0] status,
                           input int unsigned occ, input int unsigned cnt,
                           input logic empty);
    stim_row_t row;
    row.mode                = mode;
    row.value               = v;
    row.typed               = 1'b1;
    row.reply.status        = status;
    row.reply.occurrences   = OUT_CNT_W'(occ);
    row.reply.element_count = OUT_CNT_W'(cnt);
    row.reply.is_empty      = empty;
    directed_rows.push_back(row);
  endtask

  // Offers one operation and waits for its transfer.
  task automatic offer(input logic [MODE_W-1:0] mode,
                       input logic signed [VALUE_W-1:0] v,
                       input logic typed, input reply_t typed_reply);
    reply_t r;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i  <= mode;
    in_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    r = multiset_update(mode, v);
    if (r.status == STATUS_FULL) full_hits++;
    if (r.status == STATUS_ABSENT) absent_hits++;
    pending_replies.push_back(typed ? typed_reply : r);
    items_sent++;
  endtask

  task automatic offer_random(input int unsigned insert_pct);
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] v;
    int unsigned               roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) mode = MODE_INSERT;
    else if (roll < 97) mode = ($urandom_range(0, 2) != 0) ? MODE_REMOVE : MODE_LOOKUP;
    else mode = MODE_SPARE;
    // Removes and lookups mostly target a value that is actually held.
    if (mode != MODE_INSERT && shadow_held != 0 && $urandom_range(0, 9) < 7)
      v = shadow_store[$urandom_range(0, shadow_held - 1)];
    else
      v = pick_value();
    offer(mode, v, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (OP_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(input logic desc);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_desc = desc;
  endtask

  task automatic note_mismatch(input reply_t want, input reply_t got, input bit orphan);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (orphan)
        $display("reply %0d arrived with nothing pending: status %0d occ %0d count %0d empty %0b",
                 replies_seen, got.status, got.occurrences, got.element_count, got.is_empty);
      else
        $display("reply %0d: expected status %0d occ %0d count %0d empty %0b, got %0d %0d %0d %0b",
                 replies_seen, want.status, want.occurrences, want.element_count,
                 want.is_empty, got.status, got.occurrences, got.element_count, got.is_empty);
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_status_o, out_occurrences_o, out_element_count_o, out_is_empty_o};
      if (pending_replies.size() == 0) begin
        note_mismatch('0, got, 1'b1);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.occurrences !== want.occurrences ||
            got.element_count !== want.element_count || got.is_empty !== want.is_empty)
          note_mismatch(want, got, 1'b0);
      end
      replies_seen++;
    end
  end

  // Output stall: random bursts, plus one long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && items_sent >= HOLD_AT) begin
      stall_left     <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
      out_stall_i    <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    int unsigned p;
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_order(1'b0);

    add_typed(MODE_LOOKUP, 32'sh0000_0000, STATUS_ABSENT, 0, 0, 1'b1);
    add_typed(MODE_REMOVE, 32'sh8000_0000, STATUS_ABSENT, 0, 0, 1'b1);
    add_typed(MODE_INSERT, 32'sh7FFF_FFFF, STATUS_DONE, 1, 1, 1'b0);
    add_typed(MODE_INSERT, 32'sh8000_0000, STATUS_DONE, 1, 2, 1'b0);
    add_typed(MODE_INSERT, 32'sh0000_0000, STATUS_DONE, 1, 3, 1'b0);
    add_typed(MODE_INSERT, 32'sh0000_0000, STATUS_DONE, 2, 4, 1'b0);
    add_typed(MODE_INSERT, -32'sd1, STATUS_DONE, 1, 5, 1'b0);
    add_row(MODE_INSERT, 32'sh7FFF_FFFF);
    add_row(MODE_INSERT, 32'sh8000_0000);
    add_row(MODE_INSERT, 32'sh0000_0001);
    add_row(MODE_INSERT, 32'sh0000_0000);
    add_row(MODE_INSERT, 32'sh5555_5555);
    add_row(MODE_INSERT, 32'shAAAA_AAAA);
    add_row(MODE_INSERT, 32'sh7FFF_FFFE);
    add_row(MODE_INSERT, 32'sh8000_0001);
    add_row(MODE_INSERT, 32'sh7FFF_FFFF);
    add_row(MODE_INSERT, 32'sh0000_0002);
    add_row(MODE_INSERT, -32'sd2);
    // The table is full from here until the first remove below.
    add_typed(MODE_INSERT, 32'sh0000_3039, STATUS_FULL, 0, 16, 1'b0);
    add_row(MODE_INSERT, 32'sh7FFF_FFFF);
    add_row(MODE_SPARE, 32'sh0000_0000);
    add_row(MODE_LOOKUP, 32'sh8000_0000);
    add_row(MODE_REMOVE, 32'sh8000_0000);
    add_typed(MODE_REMOVE, 32'sh1234_5678, STATUS_ABSENT, 0, 15, 1'b0);
    add_row(MODE_LOOKUP, 32'sh7FFF_FFFF);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer(row.mode, row.value, row.typed, row.reply);
    end

    // The order flips with data still held; held elements keep their order.
    for (p = 0; p < PHASES; p++) begin
      drain();
      write_order(p[0] == 1'b0);
      idle_en = (p != 3) && (p != PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        offer_random(p[0] ? 35 : 60);
      end
    end
    drain();

    $display("Ran %0d operations, %0d replies checked, over %0d order settings.",
             items_sent, replies_seen, PHASES + 1);
    $display("Saw %0d inserts refused on a full table and %0d operations on absent values.",
             full_hits, absent_hits);
    if (mismatches == 0) begin
      $display("sorted_multiset_table: match");
    end else begin
      $display("sorted_multiset_table: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("sorted_multiset_table: mismatch");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/smt_pkg.sv
design/smt_cell.sv
design/smt_ctrl.sv
design/sorted_multiset_table.sv
test/tb_sorted_multiset_table.sv
